>>> hw/rtl/lpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Length-prefixed stream deframer package
// Shared types and constants for the deframer: formats, routes, result kinds.
// ----------------------------------------------------------------------------
package lpsd_pkg;

    localparam int unsigned LengthWidth = 32;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned KindWidth   = 2;

    localparam logic [LengthWidth-1:0] MaxFrameLengthReset = 32'd8388608;

    localparam logic [ByteWidth-1:0] TypeVideo = 8'h01;
    localparam logic [ByteWidth-1:0] TypeAudio = 8'h02;

    localparam logic [1:0] HeaderLastIndex = 2'd3;

    typedef enum logic [0:0] {
        OP_STREAM_BYTE = 1'b0,
        OP_CONN_START  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        FMT_UNDETECTED = 2'd0,
        FMT_LEGACY     = 2'd1,
        FMT_TYPEBYTE   = 2'd2
    } format_t;

    typedef enum logic [1:0] {
        ROUTE_VIDEO = 2'd0,
        ROUTE_AUDIO = 2'd1,
        ROUTE_DROP  = 2'd2
    } route_t;

    typedef enum logic [KindWidth-1:0] {
        KIND_VIDEO = 2'd0,
        KIND_AUDIO = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

endpackage

`default_nettype wire

>>> hw/rtl/length_prefixed_stream_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Length-prefixed stream deframer
// Splits a byte stream framed as 4-byte big-endian length plus body into
// video and audio bytes, with format detection and framing-error reports.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle and gives at most one result item
// for it in the next cycle, held in a single output register. The input side is
// ready whenever that register is empty or is being drained in the same
// cycle, so a stalled output stops the input only while a result is waiting.
// A connection-start item clears parsing and format detection but keeps the
// configured maximum frame length.
module length_prefixed_stream_deframer
    import lpsd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_wr_en,
    input  wire logic [LengthWidth-1:0] cfg_wr_data,   // max_frame_length

    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [ByteWidth-1:0]   s_axis_tdata,  // [7:0] data_byte
    input  wire logic                   s_axis_tuser,  // [0] operation

    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [ByteWidth-1:0]        m_axis_tdata,  // [7:0] payload_byte
    output logic [KindWidth-1:0]        m_axis_tuser,  // [1:0] stream_kind
    output logic                        m_axis_tlast   // last_of_frame
);

    logic [LengthWidth-1:0] max_len_reg;
    logic [1:0]             hdr_count_reg, hdr_count_next;
    logic                   in_body_reg, in_body_next;
    logic [LengthWidth-1:0] len_acc_reg, len_acc_next;
    logic [LengthWidth-1:0] remaining_reg, remaining_next;
    logic                   first_byte_reg, first_byte_next;
    format_t                format_reg, format_next;
    route_t                 route_reg, route_next;

    logic                   out_valid_reg, out_valid_next;
    logic [ByteWidth-1:0]   out_data_reg, out_data_next;
    logic [KindWidth-1:0]   out_kind_reg, out_kind_next;
    logic                   out_last_reg, out_last_next;

    logic                   accept;
    logic                   emit;
    logic [LengthWidth-1:0] len_shifted;
    logic [LengthWidth-1:0] remaining_dec;
    logic                   remaining_gt1;
    logic                   is_type_byte;
    format_t                format_eff;
    route_t                 route_eff;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign len_shifted   = {len_acc_reg[LengthWidth-ByteWidth-1:0], s_axis_tdata};
    assign remaining_dec = remaining_reg - {{(LengthWidth-1){1'b0}}, 1'b1};
    assign remaining_gt1 = |remaining_reg[LengthWidth-1:1];
    assign is_type_byte  = (s_axis_tdata == TypeVideo) || (s_axis_tdata == TypeAudio);

    always_comb
    begin
        hdr_count_next  = hdr_count_reg;
        in_body_next    = in_body_reg;
        len_acc_next    = len_acc_reg;
        remaining_next  = remaining_reg;
        first_byte_next = first_byte_reg;
        format_next     = format_reg;
        route_next      = route_reg;
        emit            = 1'b0;
        out_data_next   = s_axis_tdata;
        out_kind_next   = KIND_VIDEO;
        out_last_next   = 1'b0;
        format_eff      = format_reg;
        route_eff       = route_reg;

        if (op_t'(s_axis_tuser) == OP_CONN_START)
        begin
            hdr_count_next  = 2'd0;
            in_body_next    = 1'b0;
            len_acc_next    = '0;
            remaining_next  = '0;
            first_byte_next = 1'b0;
            format_next     = FMT_UNDETECTED;
            route_next      = ROUTE_VIDEO;
        end
        else if (!in_body_reg)
        begin
            len_acc_next   = len_shifted;
            hdr_count_next = hdr_count_reg + 2'd1;
            if (hdr_count_reg == HeaderLastIndex)
            begin
                len_acc_next = '0;
                if (len_shifted > max_len_reg)
                begin
                    emit          = 1'b1;
                    out_data_next = '0;
                    out_kind_next = KIND_ERROR;
                    out_last_next = 1'b1;
                end
                else if (len_shifted != '0)
                begin
                    in_body_next    = 1'b1;
                    remaining_next  = len_shifted;
                    first_byte_next = 1'b1;
                end
            end
        end
        else
        begin
            if (first_byte_reg)
            begin
                first_byte_next = 1'b0;
                route_eff       = ROUTE_VIDEO;
                if (format_reg == FMT_UNDETECTED && remaining_gt1)
                begin
                    format_eff = is_type_byte ? FMT_TYPEBYTE : FMT_LEGACY;
                end
                format_next = format_eff;
            end

            if (first_byte_reg && format_eff == FMT_TYPEBYTE && remaining_gt1)
            begin
                if (s_axis_tdata == TypeVideo)
                begin
                    route_next = ROUTE_VIDEO;
                end
                else if (s_axis_tdata == TypeAudio)
                begin
                    route_next = ROUTE_AUDIO;
                end
                else
                begin
                    route_next = ROUTE_DROP;
                end
                remaining_next = remaining_dec;
            end
            else
            begin
                route_next     = route_eff;
                emit           = (route_eff != ROUTE_DROP);
                out_kind_next  = KindWidth'(route_eff);
                out_last_next  = !remaining_gt1;
                remaining_next = remaining_dec;
                if (remaining_dec == '0)
                begin
                    in_body_next = 1'b0;
                end
            end
        end

        if (accept)
        begin
            out_valid_next = emit;
        end
        else
        begin
            out_valid_next = out_valid_reg && !m_axis_tready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= MaxFrameLengthReset;
            hdr_count_reg  <= 2'd0;
            in_body_reg    <= 1'b0;
            len_acc_reg    <= '0;
            remaining_reg  <= '0;
            first_byte_reg <= 1'b0;
            format_reg     <= FMT_UNDETECTED;
            route_reg      <= ROUTE_VIDEO;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                hdr_count_reg  <= hdr_count_next;
                in_body_reg    <= in_body_next;
                len_acc_reg    <= len_acc_next;
                remaining_reg  <= remaining_next;
                first_byte_reg <= first_byte_next;
                format_reg     <= format_next;
                route_reg      <= route_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_data_reg <= out_data_next;
            out_kind_reg <= out_kind_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed stream deframer testbench
// Drives framed byte streams, connection starts, oversized lengths and noise
// into the deframer under changing maximum frame lengths and flow-control
// patterns, and checks every output item against a cycle-free model of the
// header parser, format detection and routing.
// ----------------------------------------------------------------------------
import lpsd_pkg::*;

typedef struct packed {
    logic [ByteWidth-1:0] payload;
    kind_t                kind;
    logic                 end_of_frame;
} deframed_byte_t;

class deframe_tracker;
    logic [LengthWidth-1:0] max_len;
    logic [1:0]             header_count;
    logic                   in_body;
    logic [LengthWidth-1:0] length_acc;
    logic [LengthWidth-1:0] body_left;
    logic                   at_lead_byte;
    format_t                detected_format;
    route_t                 route;
    deframed_byte_t         expected_bytes[$];
    int unsigned            mismatches;

    function void clear_connection();
        header_count    = 2'd0;
        in_body         = 1'b0;
        length_acc      = '0;
        body_left       = '0;
        at_lead_byte    = 1'b0;
        detected_format = FMT_UNDETECTED;
        route           = ROUTE_VIDEO;
    endfunction

    function void reset_all();
        max_len    = MaxFrameLengthReset;
        mismatches = 0;
        expected_bytes.delete();
        clear_connection();
    endfunction

    function int unsigned pending();
        return expected_bytes.size();
    endfunction

    function void accept_item(op_t op, logic [ByteWidth-1:0] data);
        deframed_byte_t entry;
        if (op == OP_CONN_START)
        begin
            clear_connection();
            return;
        end
        if (!in_body)
        begin
            length_acc   = {length_acc[LengthWidth-9:0], data};
            header_count = header_count + 2'd1;
            if (header_count != 2'd0)
                return;
            if (length_acc > max_len)
            begin
                entry.payload      = '0;
                entry.kind         = KIND_ERROR;
                entry.end_of_frame = 1'b1;
                expected_bytes.push_back(entry);
            end
            else if (length_acc != 0)
            begin
                in_body      = 1'b1;
                body_left    = length_acc;
                at_lead_byte = 1'b1;
            end
            length_acc = '0;
            return;
        end
        if (at_lead_byte)
        begin
            at_lead_byte = 1'b0;
            route        = ROUTE_VIDEO;
            if (detected_format == FMT_UNDETECTED && body_left > 1)
                detected_format = (data == TypeVideo || data == TypeAudio) ?
                                  FMT_TYPEBYTE : FMT_LEGACY;
            if (detected_format == FMT_TYPEBYTE && body_left > 1)
            begin
                route = (data == TypeVideo) ? ROUTE_VIDEO :
                        (data == TypeAudio) ? ROUTE_AUDIO : ROUTE_DROP;
                body_left = body_left - 1;
                return;
            end
        end
        if (route != ROUTE_DROP)
        begin
            entry.payload      = data;
            entry.kind         = (route == ROUTE_AUDIO) ? KIND_AUDIO : KIND_VIDEO;
            entry.end_of_frame = (body_left == 1);
            expected_bytes.push_back(entry);
        end
        body_left = body_left - 1;
        if (body_left == 0)
            in_body = 1'b0;
    endfunction

    function void check_output(logic [ByteWidth-1:0] payload, logic [KindWidth-1:0] kind,
                               logic end_of_frame);
        deframed_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected item payload %02h kind %0d last %0b",
                         payload, kind, end_of_frame);
            return;
        end
        want = expected_bytes.pop_front();
        if (payload !== want.payload || kind !== want.kind ||
            end_of_frame !== want.end_of_frame)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: expected payload %02h kind %0d last %0b, got %02h %0d %0b",
                         want.payload, want.kind, want.end_of_frame,
                         payload, kind, end_of_frame);
        end
    endfunction
endclass

module testbench;

    localparam int unsigned StallLimit   = 2000;
    localparam int unsigned SegmentItems = 300;
    localparam int unsigned HoldCycles   = 80;
    localparam int unsigned SettleCycles = 4;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [LengthWidth-1:0] cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [ByteWidth-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [ByteWidth-1:0]   m_axis_tdata;
    logic [KindWidth-1:0]   m_axis_tuser;
    logic                   m_axis_tlast;

    deframe_tracker tracker = new;
    int unsigned    sender_idle_pct;
    int unsigned    receiver_idle_pct;
    int unsigned    hold_request;
    int unsigned    items_sent;

    length_prefixed_stream_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_item(op_t op, logic [ByteWidth-1:0] data);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.accept_item(op, data);
        items_sent++;
    endtask

    task automatic send_length(logic [LengthWidth-1:0] len);
        for (int i = 3; i >= 0; i--)
            send_item(OP_STREAM_BYTE, len[8*i +: 8]);
    endtask

    task automatic send_body(int unsigned len, logic [ByteWidth-1:0] lead);
        if (len == 0)
            return;
        send_item(OP_STREAM_BYTE, lead);
        repeat (len - 1)
            send_item(OP_STREAM_BYTE, 8'($urandom_range(255)));
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic pause_until_idle();
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_max_length(logic [LengthWidth-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.max_len = value;
    endtask

    task automatic send_random_frame();
        int unsigned            pick;
        int unsigned            len;
        int unsigned            lead_pick;
        logic [LengthWidth-1:0] span;
        logic [LengthWidth-1:0] oversized;
        logic [ByteWidth-1:0]   lead;
        pick = $urandom_range(99);
        if (pick < 8 && tracker.max_len != '1)
        begin
            span      = '1 - tracker.max_len;
            oversized = $urandom_range(1) ? tracker.max_len + 1 :
                        tracker.max_len + 1 + ($urandom % span);
            send_length(oversized);
        end
        else if (pick < 13)
        begin
            repeat ($urandom_range(1, 6))
                send_item(OP_STREAM_BYTE, 8'($urandom_range(255)));
        end
        else if (pick < 17)
        begin
            repeat ($urandom_range(1, 6))
                send_item(OP_STREAM_BYTE, 8'($urandom_range(7)));
            send_item(OP_CONN_START, 8'($urandom_range(255)));
        end
        else
        begin
            pick = $urandom_range(99);
            len  = (pick < 70) ? $urandom_range(0, 6) :
                   (pick < 95) ? $urandom_range(7, 40) : $urandom_range(41, 300);
            if (len > tracker.max_len)
                len = tracker.max_len;
            lead_pick = $urandom_range(99);
            lead = (lead_pick < 35) ? TypeVideo :
                   (lead_pick < 65) ? TypeAudio :
                   (lead_pick < 75) ? 8'h00 : 8'($urandom_range(255));
            send_length(len);
            send_body(len, lead);
        end
    endtask

    task automatic run_connections(int unsigned quota, bit with_pause);
        int unsigned first;
        bit          paused;
        first  = items_sent;
        paused = 1'b0;
        while (items_sent - first < quota)
        begin
            send_item(OP_CONN_START, 8'($urandom_range(255)));
            repeat ($urandom_range(2, 10))
                send_random_frame();
            if (with_pause && !paused && items_sent - first > quota / 2)
            begin
                pause_until_idle();
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < StallLimit)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [LengthWidth-1:0] setting;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_STREAM_BYTE;
        sender_idle_pct   = 14;
        receiver_idle_pct = 64;
        hold_request      = 0;
        items_sent        = 0;
        tracker.reset_all();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty body, one-byte body, type-byte detection, unknown type, oversize.
        send_length(0);
        send_length(1);
        send_item(OP_STREAM_BYTE, TypeVideo);
        send_length(2);
        send_item(OP_STREAM_BYTE, TypeAudio);
        send_item(OP_STREAM_BYTE, 8'hFF);
        send_length(2);
        send_item(OP_STREAM_BYTE, 8'h07);
        send_item(OP_STREAM_BYTE, 8'h00);
        send_length('1);
        // A new connection detects legacy framing from a non-type lead byte.
        send_item(OP_CONN_START, 8'hFF);
        send_length(2);
        send_item(OP_STREAM_BYTE, 8'h80);
        send_item(OP_STREAM_BYTE, TypeVideo);

        for (int seg = 0; seg < 6; seg++)
        begin
            sender_idle_pct   = (seg < 2) ? 14 : (seg < 4) ? 64 : 0;
            receiver_idle_pct = (seg < 2) ? 64 : (seg < 4) ? 14 : 0;
            if (seg > 0)
            begin
                case (seg)
                    1:       setting = 32'd1;
                    2:       setting = '1;
                    3:       setting = 32'd16;
                    4:       setting = $urandom_range(2, 64);
                    default: setting = $urandom;
                endcase
                if (setting == 0)
                    setting = 32'd1;
                pause_until_idle();
                write_max_length(setting);
            end
            if (seg == 1 || seg == 4)
                hold_request = HoldCycles;
            run_connections(SegmentItems, seg == 3);
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> length_prefixed_stream_deframer.f
hw/rtl/lpsd_pkg.sv
hw/rtl/length_prefixed_stream_deframer.sv
verif/testbench.sv
